### src/sppa_pkg.sv
// Package for the sparse polynomial adder: defaults, kind codes, sequencer states, unit flags.
`default_nettype none
package sppa_pkg;

    localparam int DEF_MAX_TERMS = 32;
    localparam int DEF_COEF_BITS = 16;
    localparam int DEF_EXP_BITS  = 8;

    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_LOAD_FIRST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_SECOND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUM         = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_HEAD,
        ST_SUM_EMPTY,
        ST_MERGE
    } state_t;

    // Result of the shared compare unit.
    typedef struct packed {
        logic gt;      // a_exp > b_exp
        logic lt;      // a_exp < b_exp
        logic take_a;  // merge consumes the first head
        logic take_b;  // merge consumes the second head
    } cmp_t;

endpackage
`default_nettype wire

### src/sppa_store.sv
// Term store: one write port and one registered read port.
`default_nettype none
module sppa_store #(
    parameter int DEPTH  = sppa_pkg::DEF_MAX_TERMS,
    parameter int DATA_W = sppa_pkg::DEF_COEF_BITS + sppa_pkg::DEF_EXP_BITS
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

### src/sppa_unit.sv
// Shared exponent compare, merge pick and coefficient adder.
`default_nettype none
module sppa_unit #(
    parameter int COEF_BITS = sppa_pkg::DEF_COEF_BITS,
    parameter int EXP_BITS  = sppa_pkg::DEF_EXP_BITS
) (
    input  wire logic        [EXP_BITS-1:0]  a_exp,
    input  wire logic        [EXP_BITS-1:0]  b_exp,
    input  wire logic signed [COEF_BITS-1:0] a_coef,
    input  wire logic signed [COEF_BITS-1:0] b_coef,
    input  wire logic                        a_has,
    input  wire logic                        b_has,
    output sppa_pkg::cmp_t                   cmp,
    output logic signed      [COEF_BITS:0]   sum
);
    import sppa_pkg::*;

    logic signed [COEF_BITS:0] a_ext;
    logic signed [COEF_BITS:0] b_ext;

    always_comb
    begin
        cmp.gt     = (a_exp > b_exp);
        cmp.lt     = (a_exp < b_exp);
        // equal heads take both; an exhausted side never gets picked
        cmp.take_a = !b_has || (a_has && !cmp.lt);
        cmp.take_b = !a_has || (b_has && !cmp.gt);
        a_ext      = cmp.take_a ? {a_coef[COEF_BITS-1], a_coef} : '0;
        b_ext      = cmp.take_b ? {b_coef[COEF_BITS-1], b_coef} : '0;
        sum        = a_ext + b_ext;
    end

endmodule
`default_nettype wire

### src/sparse_polynomial_adder.sv
// Top level of the sparse polynomial adder: sequencer, two term stores, result register.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+---------------------------------
//  cmd     | cmd_valid, cmd_ready, kind, coefficient,  | load a term into a store, or
//          | exponent                                  | sum both stores and clear them
//  res     | res_valid, res_ready, sum_coefficient,    | merged terms, last beat flagged
//          | sum_exponent, empty_res, overflow, last   | by last
//
// Sequencing: a load into an empty or full store is handled in idle; otherwise the sequencer walks
// the store from its tail, one entry per cycle (move up or stop), plus one head write when
// every entry moves. A sum walks both stores and emits one beat per merged exponent.
// Reset: counts, overflow flag and state clear at once; no memory clearing pass.
// Stalls: cmd_ready is high only in idle; a held res beat stalls the merge walk, and the
// block still takes commands in idle while the last beat waits in the result register.
`default_nettype none
module sparse_polynomial_adder #(
    parameter int MAX_TERMS = sppa_pkg::DEF_MAX_TERMS,
    parameter int COEF_BITS = sppa_pkg::DEF_COEF_BITS,
    parameter int EXP_BITS  = sppa_pkg::DEF_EXP_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_ready,
    input  wire logic [sppa_pkg::KIND_W-1:0] kind,
    input  wire logic signed [COEF_BITS-1:0] coefficient,
    input  wire logic        [EXP_BITS-1:0]  exponent,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output logic signed      [COEF_BITS:0]   sum_coefficient,
    output logic             [EXP_BITS-1:0]  sum_exponent,
    output logic                             empty_res,
    output logic                             overflow,
    output logic                             last
);
    import sppa_pkg::*;

    localparam int AW     = $clog2(MAX_TERMS);
    localparam int CW     = $clog2(MAX_TERMS + 1);
    localparam int DATA_W = COEF_BITS + EXP_BITS;

    state_t state_reg, state_next;

    logic                 sel_reg, sel_next;          // 1: second store
    logic [COEF_BITS-1:0] new_coef_reg, new_coef_next;
    logic [EXP_BITS-1:0]  new_exp_reg, new_exp_next;
    logic [AW-1:0]        k_reg, k_next;              // walk position during insert
    logic [CW-1:0]        cnt1_reg, cnt1_next;
    logic [CW-1:0]        cnt2_reg, cnt2_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [CW-1:0]        j_reg, j_next;
    logic                 ovf_reg, ovf_next;

    // result register
    logic                      rv_reg, rv_next;
    logic signed [COEF_BITS:0] rc_reg, rc_next;
    logic [EXP_BITS-1:0]       re_reg, re_next;
    logic                      rempty_reg, rempty_next;
    logic                      rovf_reg, rovf_next;   // flag as it stood when the beat formed
    logic                      rlast_reg, rlast_next;
    logic                      out_load;
    logic                      out_free;

    // store ports
    logic              wr_en, wr_sel;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr1, rd_addr2;
    logic [DATA_W-1:0] rd_data1, rd_data2;

    // shared unit operands
    logic        [EXP_BITS-1:0]  ua_exp, ub_exp;
    logic signed [COEF_BITS-1:0] ua_coef, ub_coef;
    logic                        ua_has, ub_has;
    cmp_t                        ucmp;
    logic signed [COEF_BITS:0]   usum;

    logic [DATA_W-1:0] d_sel;      // entry read from the store being inserted into
    logic              ld_sel;
    logic [CW-1:0]     ld_cnt;
    logic              move;
    logic              last_beat;

    sppa_store #(.DEPTH(MAX_TERMS), .DATA_W(DATA_W)) u_first (
        .clk     (clk),
        .wr_en   (wr_en && !wr_sel),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr1),
        .rd_data (rd_data1)
    );

    sppa_store #(.DEPTH(MAX_TERMS), .DATA_W(DATA_W)) u_second (
        .clk     (clk),
        .wr_en   (wr_en && wr_sel),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr2),
        .rd_data (rd_data2)
    );

    sppa_unit #(.COEF_BITS(COEF_BITS), .EXP_BITS(EXP_BITS)) u_unit (
        .a_exp  (ua_exp),
        .b_exp  (ub_exp),
        .a_coef (ua_coef),
        .b_coef (ub_coef),
        .a_has  (ua_has),
        .b_has  (ub_has),
        .cmp    (ucmp),
        .sum    (usum)
    );

    assign d_sel    = sel_reg ? rd_data2 : rd_data1;
    assign out_free = !rv_reg || res_ready;

    // Operand mux: insert compares the new exponent to the read entry,
    // merge compares the two store heads.
    always_comb
    begin
        if (state_reg == ST_MERGE)
        begin
            ua_exp  = rd_data1[EXP_BITS-1:0];
            ub_exp  = rd_data2[EXP_BITS-1:0];
            ua_coef = rd_data1[DATA_W-1:EXP_BITS];
            ub_coef = rd_data2[DATA_W-1:EXP_BITS];
            ua_has  = (i_reg < cnt1_reg);
            ub_has  = (j_reg < cnt2_reg);
        end
        else
        begin
            ua_exp  = new_exp_reg;
            ub_exp  = d_sel[EXP_BITS-1:0];
            ua_coef = new_coef_reg;
            ub_coef = d_sel[DATA_W-1:EXP_BITS];
            ua_has  = 1'b1;
            ub_has  = 1'b1;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        new_coef_next = new_coef_reg;
        new_exp_next  = new_exp_reg;
        k_next        = k_reg;
        cnt1_next     = cnt1_reg;
        cnt2_next     = cnt2_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        ovf_next      = ovf_reg;

        wr_en    = 1'b0;
        wr_sel   = sel_reg;
        wr_addr  = '0;
        wr_data  = '0;
        rd_addr1 = i_reg[AW-1:0];
        rd_addr2 = j_reg[AW-1:0];

        out_load    = 1'b0;
        rc_next     = rc_reg;
        re_next     = re_reg;
        rempty_next = rempty_reg;
        rovf_next   = rovf_reg;
        rlast_next  = rlast_reg;

        cmd_ready = (state_reg == ST_IDLE);
        ld_sel    = (kind == KIND_LOAD_SECOND);
        ld_cnt    = ld_sel ? cnt2_reg : cnt1_reg;
        move      = (k_reg == '0) ? ucmp.gt : !ucmp.lt;
        last_beat = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (kind)
                        KIND_LOAD_FIRST, KIND_LOAD_SECOND:
                        begin
                            sel_next      = ld_sel;
                            new_coef_next = coefficient;
                            new_exp_next  = exponent;
                            if (ld_cnt == CW'(MAX_TERMS))
                            begin
                                ovf_next = 1'b1;
                            end
                            else if (ld_cnt == '0)
                            begin
                                wr_en   = 1'b1;
                                wr_sel  = ld_sel;
                                wr_addr = '0;
                                wr_data = {coefficient, exponent};
                                if (ld_sel)
                                    cnt2_next = cnt2_reg + CW'(1);
                                else
                                    cnt1_next = cnt1_reg + CW'(1);
                            end
                            else
                            begin
                                // start at the tail and walk down
                                k_next = AW'(ld_cnt - CW'(1));
                                if (ld_sel)
                                    rd_addr2 = AW'(ld_cnt - CW'(1));
                                else
                                    rd_addr1 = AW'(ld_cnt - CW'(1));
                                state_next = ST_INS_CHK;
                            end
                        end
                        KIND_SUM:
                        begin
                            if (cnt1_reg == '0 && cnt2_reg == '0)
                            begin
                                state_next = ST_SUM_EMPTY;
                            end
                            else
                            begin
                                i_next     = '0;
                                j_next     = '0;
                                rd_addr1   = '0;
                                rd_addr2   = '0;
                                state_next = ST_MERGE;
                            end
                        end
                        default:
                        begin
                            // unused kind: dropped
                        end
                    endcase
                end
            end

            ST_INS_CHK:
            begin
                wr_en   = 1'b1;
                wr_addr = k_reg + AW'(1);
                if (move)
                begin
                    wr_data = d_sel;
                    if (k_reg == '0)
                    begin
                        state_next = ST_INS_HEAD;
                    end
                    else
                    begin
                        k_next = k_reg - AW'(1);
                        if (sel_reg)
                            rd_addr2 = k_reg - AW'(1);
                        else
                            rd_addr1 = k_reg - AW'(1);
                    end
                end
                else
                begin
                    wr_data = {new_coef_reg, new_exp_reg};
                    if (sel_reg)
                        cnt2_next = cnt2_reg + CW'(1);
                    else
                        cnt1_next = cnt1_reg + CW'(1);
                    state_next = ST_IDLE;
                end
            end

            ST_INS_HEAD:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = {new_coef_reg, new_exp_reg};
                if (sel_reg)
                    cnt2_next = cnt2_reg + CW'(1);
                else
                    cnt1_next = cnt1_reg + CW'(1);
                state_next = ST_IDLE;
            end

            ST_SUM_EMPTY:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    rc_next     = '0;
                    re_next     = '0;
                    rempty_next = 1'b1;
                    rovf_next   = ovf_reg;
                    rlast_next  = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            ST_MERGE:
            begin
                if (out_free)
                begin
                    i_next    = i_reg + CW'(ucmp.take_a);
                    j_next    = j_reg + CW'(ucmp.take_b);
                    rd_addr1  = i_next[AW-1:0];
                    rd_addr2  = j_next[AW-1:0];
                    last_beat = (i_next >= cnt1_reg) && (j_next >= cnt2_reg);

                    out_load    = 1'b1;
                    rc_next     = usum;
                    re_next     = ucmp.take_a ? ua_exp : ub_exp;
                    rempty_next = 1'b0;
                    rovf_next   = ovf_reg;
                    rlast_next  = last_beat;
                    if (last_beat)
                    begin
                        cnt1_next  = '0;
                        cnt2_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
            rv_next = 1'b1;
        else if (res_ready)
            rv_next = 1'b0;
        else
            rv_next = rv_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt1_reg  <= '0;
            cnt2_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            sel_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt1_reg  <= cnt1_next;
            cnt2_reg  <= cnt2_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            sel_reg   <= sel_next;
            ovf_reg   <= ovf_next;
            rv_reg    <= rv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        new_coef_reg <= new_coef_next;
        new_exp_reg  <= new_exp_next;
        rc_reg       <= rc_next;
        re_reg       <= re_next;
        rempty_reg   <= rempty_next;
        rovf_reg     <= rovf_next;
        rlast_reg    <= rlast_next;
    end

    assign res_valid       = rv_reg;
    assign sum_coefficient = rc_reg;
    assign sum_exponent    = re_reg;
    assign empty_res       = rempty_reg;
    assign overflow        = rovf_reg;
    assign last            = rlast_reg;

endmodule
`default_nettype wire

### sim/tb.sv
// Self-checking testbench for sparse_polynomial_adder: random term loads and sums checked beat by beat.
module tb;
    import sppa_pkg::*;

    localparam int MAX_TERMS = DEF_MAX_TERMS;
    localparam int CW        = DEF_COEF_BITS;
    localparam int EW        = DEF_EXP_BITS;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;   // no operation, block ignores it

    localparam int FIRST  = 0;
    localparam int SECOND = 1;

    localparam int RANDOM_ITEMS = 410;
    localparam int HOLD_CYCLES  = 400;      // long receiver hold-off in the last phase
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic signed [CW-1:0] coef;
        logic [EW-1:0]        expo;
    } command_t;

    typedef struct {
        logic signed [CW:0] coef;
        logic [EW-1:0]      expo;
        logic               empty;
        logic               ovf;
        logic               fin;
    } sum_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cmd_valid = 1'b0;
    logic                 cmd_ready;
    logic [KIND_W-1:0]    kind = KIND_LOAD_FIRST;
    logic signed [CW-1:0] coefficient = '0;
    logic [EW-1:0]        exponent = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    logic signed [CW:0]   sum_coefficient;
    logic [EW-1:0]        sum_exponent;
    logic                 empty_res;
    logic                 overflow;
    logic                 last;

    sparse_polynomial_adder #(
        .MAX_TERMS(MAX_TERMS),
        .COEF_BITS(CW),
        .EXP_BITS(EW)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .kind(kind),
        .coefficient(coefficient),
        .exponent(exponent),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .sum_coefficient(sum_coefficient),
        .sum_exponent(sum_exponent),
        .empty_res(empty_res),
        .overflow(overflow),
        .last(last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow state of the two term stores
    logic signed [CW-1:0] term_coef [2][MAX_TERMS];
    logic [EW-1:0]        term_exp  [2][MAX_TERMS];
    int                   term_count [2] = '{0, 0};
    logic                 overflow_seen = 1'b0;

    command_t  commands_pending [$];
    sum_beat_t sum_terms_due [$];

    int   total_commands = 0;
    int   commands_taken = 0;
    int   beats_seen = 0;
    int   mismatches = 0;
    int   cycles = 0;
    logic [1:0] phase = 2'd0;
    int   tx_idle_pct = 26;
    int   rx_idle_pct = 56;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // Sorted insertion: in front only above the head, else after the head
    // and past every strictly greater exponent.
    task automatic place_term(input int s, input logic signed [CW-1:0] c,
                              input logic [EW-1:0] e);
        int n;
        int pos;
        int k;
        n = term_count[s];
        if (n >= MAX_TERMS)
        begin
            overflow_seen = 1'b1;
            return;
        end
        if (n == 0 || e > term_exp[s][0])
            pos = 0;
        else
        begin
            pos = 1;
            while (pos < n && e < term_exp[s][pos])
                pos++;
        end
        for (k = n; k > pos; k--)
        begin
            term_coef[s][k] = term_coef[s][k-1];
            term_exp[s][k]  = term_exp[s][k-1];
        end
        term_coef[s][pos] = c;
        term_exp[s][pos]  = e;
        term_count[s]     = n + 1;
    endtask

    // Predict the beats of one accepted command
    task automatic apply_command(input logic [KIND_W-1:0] k, input logic signed [CW-1:0] c,
                                 input logic [EW-1:0] e);
        int i;
        int j;
        sum_beat_t b;
        i = 0;
        j = 0;
        if (k == KIND_LOAD_FIRST)
            place_term(FIRST, c, e);
        else if (k == KIND_LOAD_SECOND)
            place_term(SECOND, c, e);
        else if (k == KIND_SUM)
        begin
            if (term_count[FIRST] == 0 && term_count[SECOND] == 0)
            begin
                b.coef  = '0;
                b.expo  = '0;
                b.empty = 1'b1;
                b.ovf   = overflow_seen;
                b.fin   = 1'b1;
                sum_terms_due.push_back(b);
            end
            else
            begin
                while (i < term_count[FIRST] || j < term_count[SECOND])
                begin
                    if (j >= term_count[SECOND] ||
                        (i < term_count[FIRST] && term_exp[FIRST][i] > term_exp[SECOND][j]))
                    begin
                        b.coef = term_coef[FIRST][i];
                        b.expo = term_exp[FIRST][i];
                        i++;
                    end
                    else if (i >= term_count[FIRST] ||
                             term_exp[FIRST][i] < term_exp[SECOND][j])
                    begin
                        b.coef = term_coef[SECOND][j];
                        b.expo = term_exp[SECOND][j];
                        j++;
                    end
                    else
                    begin
                        b.coef = term_coef[FIRST][i] + term_coef[SECOND][j];
                        b.expo = term_exp[FIRST][i];
                        i++;
                        j++;
                    end
                    b.empty = 1'b0;
                    b.ovf   = overflow_seen;
                    b.fin   = (i >= term_count[FIRST] && j >= term_count[SECOND]);
                    sum_terms_due.push_back(b);
                end
                term_count[FIRST]  = 0;
                term_count[SECOND] = 0;
            end
        end
    endtask

    task automatic queue_command(input logic [KIND_W-1:0] k, input logic signed [CW-1:0] c,
                                 input logic [EW-1:0] e);
        command_t cmd;
        cmd.kind = k;
        cmd.coef = c;
        cmd.expo = e;
        commands_pending.push_back(cmd);
    endtask

    function automatic logic signed [CW-1:0] pick_coef();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return {1'b1, {(CW-1){1'b0}}};
        else if (roll < 10)
            return {1'b0, {(CW-1){1'b1}}};
        else if (roll < 13)
            return '0;
        else if (roll < 16)
            return '1;
        return CW'($urandom);
    endfunction

    function automatic logic [EW-1:0] pick_expo(input int span);
        if (span == (1 << EW) - 1 && $urandom_range(9) == 0)
            return $urandom_range(1) ? '1 : '0;
        return EW'($urandom_range(span));
    endfunction

    // Mostly short polynomials; near-full stores at any time, overflowing stores late in the run
    function automatic int pick_size(input bit allow_overflow);
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom_range(5);
        else if (roll < 95)
            return $urandom_range(16, 6);
        else if (allow_overflow)
            return $urandom_range(MAX_TERMS + 3, MAX_TERMS - 2);
        return $urandom_range(MAX_TERMS, MAX_TERMS - 4);
    endfunction

    // Driver: one beat offered at a time, new payload only after acceptance
    always @(posedge clk)
    begin : driver
        command_t next_cmd;
        if (!rst_n)
            cmd_valid <= 1'b0;
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                apply_command(kind, coefficient, exponent);
                commands_taken++;
            end
            if (!cmd_valid || cmd_ready)
            begin
                if (commands_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    next_cmd = commands_pending.pop_front();
                    cmd_valid   <= 1'b1;
                    kind        <= next_cmd.kind;
                    coefficient <= next_cmd.coef;
                    exponent    <= next_cmd.expo;
                end
                else
                    cmd_valid <= 1'b0;
            end
            // idle mix: sender-heavy receiver stalls, then the reverse, then none
            if (commands_taken < total_commands / 3)
            begin
                phase       <= 2'd0;
                tx_idle_pct <= 26;
                rx_idle_pct <= 56;
            end
            else if (commands_taken < 2 * total_commands / 3)
            begin
                phase       <= 2'd1;
                tx_idle_pct <= 56;
                rx_idle_pct <= 26;
            end
            else
            begin
                phase       <= 2'd2;
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
        end
    end

    // Monitor: checks each beat against the oldest prediction
    always @(posedge clk)
    begin : monitor
        sum_beat_t want;
        int  hold_left;
        bit  hold_done;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (sum_terms_due.size() == 0)
                    report($sformatf("beat %0d arrived with nothing predicted", beats_seen));
                else
                begin
                    want = sum_terms_due.pop_front();
                    if (sum_coefficient !== want.coef)
                        report($sformatf("beat %0d sum_coefficient %0d, expected %0d",
                                         beats_seen, sum_coefficient, want.coef));
                    if (sum_exponent !== want.expo)
                        report($sformatf("beat %0d sum_exponent %0d, expected %0d",
                                         beats_seen, sum_exponent, want.expo));
                    if (empty_res !== want.empty)
                        report($sformatf("beat %0d empty_res %b, expected %b",
                                         beats_seen, empty_res, want.empty));
                    if (overflow !== want.ovf)
                        report($sformatf("beat %0d overflow %b, expected %b",
                                         beats_seen, overflow, want.ovf));
                    if (last !== want.fin)
                        report($sformatf("beat %0d last %b, expected %b",
                                         beats_seen, last, want.fin));
                end
                beats_seen++;
            end
            // back-pressure: block fills and drops cmd_ready while sender keeps offering
            if (!hold_done && phase == 2'd2)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else
                res_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        int counted;
        int n_a;
        int n_b;
        int span;
        int roll;
        logic [KIND_W-1:0] k;
        counted = 0;

        // directed: empty sum, ignored kind, extremes, ties, head inserts, zero sum
        queue_command(KIND_SUM, '0, '0);
        queue_command(KIND_UNUSED, 16'sh1234, 8'h5a);
        queue_command(KIND_LOAD_FIRST, 16'sd5, 8'd10);
        queue_command(KIND_LOAD_FIRST, 16'sd7, 8'd20);
        queue_command(KIND_LOAD_FIRST, -16'sd32768, 8'd20);
        queue_command(KIND_LOAD_FIRST, 16'sd1, 8'd0);
        queue_command(KIND_LOAD_FIRST, 16'sd32767, 8'd255);
        queue_command(KIND_LOAD_FIRST, 16'sd3, 8'd255);
        queue_command(KIND_LOAD_FIRST, 16'sd11, 8'd15);
        queue_command(KIND_LOAD_SECOND, 16'sd32767, 8'd255);
        queue_command(KIND_LOAD_SECOND, -16'sd32768, 8'd20);
        queue_command(KIND_LOAD_SECOND, -16'sd32768, 8'd20);
        queue_command(KIND_LOAD_SECOND, -16'sd5, 8'd10);
        queue_command(KIND_LOAD_SECOND, -16'sd1, 8'd128);
        queue_command(KIND_UNUSED, -16'sd1, 8'hff);
        queue_command(KIND_SUM, '0, '0);
        queue_command(KIND_LOAD_FIRST, 16'sd1, 8'd2);
        queue_command(KIND_SUM, 16'sh7fff, 8'hff);
        queue_command(KIND_LOAD_SECOND, 16'sd9, 8'd128);
        queue_command(KIND_SUM, '0, '0);

        // random: mostly well-formed load runs closed by a sum, some noise
        while (counted < RANDOM_ITEMS)
        begin
            roll = $urandom_range(99);
            if (roll < 15)
            begin
                k = KIND_W'($urandom_range(3));
                queue_command(k, CW'($urandom), EW'($urandom));
                if (k != KIND_UNUSED)
                    counted++;
            end
            else
            begin
                n_a = pick_size(counted > 3 * RANDOM_ITEMS / 4);
                n_b = pick_size(counted > 3 * RANDOM_ITEMS / 4);
                case ($urandom_range(2))
                    0: span = 3;
                    1: span = 15;
                    default: span = (1 << EW) - 1;
                endcase
                while (n_a > 0 || n_b > 0)
                begin
                    if (n_b == 0 || (n_a > 0 && $urandom_range(1) == 1))
                    begin
                        queue_command(KIND_LOAD_FIRST, pick_coef(), pick_expo(span));
                        n_a--;
                    end
                    else
                    begin
                        queue_command(KIND_LOAD_SECOND, pick_coef(), pick_expo(span));
                        n_b--;
                    end
                    counted++;
                    // stray item breaking the run now and then
                    if ($urandom_range(99) < 3)
                    begin
                        k = $urandom_range(1) ? KIND_UNUSED : KIND_SUM;
                        queue_command(k, CW'($urandom), EW'($urandom));
                        if (k != KIND_UNUSED)
                            counted++;
                    end
                end
                queue_command(KIND_SUM, CW'($urandom), EW'($urandom));
                counted++;
            end
        end
        total_commands = commands_pending.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (commands_taken < total_commands)
            @(negedge clk);
        while (sum_terms_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && sum_terms_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
src/sppa_pkg.sv
src/sppa_store.sv
src/sppa_unit.sv
src/sparse_polynomial_adder.sv
sim/tb.sv
